// File: hw/rtl/nnta_pkg.sv
// shared constants, command struct and register codes for the track association block
// no dependencies; used by nnta_ctrl, nnta_dp, nearest_neighbor_track_association and the testbench

package nnta_pkg;

    localparam int MAX_TRACKS = 16;
    localparam int SLOT_W     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    localparam int POS_W      = 16;
    localparam int ID_W       = 16;
    localparam int FRAMES_W   = 16;
    localparam int AGE_W      = 8;
    localparam int RADIUS_W   = 15;
    localparam int SQ_W       = 2 * POS_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET    = RADIUS_W'(500);
    localparam logic [AGE_W-1:0]    AGE_LIMIT_RESET = AGE_W'(10);

    localparam logic CMD_FRAME  = 1'b0;
    localparam logic CMD_DETECT = 1'b1;

    typedef enum logic {
        REG_MATCH_RADIUS = 1'b0,
        REG_AGE_LIMIT    = 1'b1
    } reg_index_t;

    // controller to datapath commands
    typedef struct packed {
        logic              load_frame;
        logic              load_det;
        logic              age_en;
        logic              scan_en;
        logic              commit;
        logic [SLOT_W-1:0] idx;
    } nnta_cmd_t;

endpackage

// File: hw/rtl/nnta_ctrl.sv
// sequencer for the track association block: frame aging sweep, detection scan, commit
// depends on nnta_pkg

module nnta_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    output logic                out_valid,
    input  logic                out_stall,
    output nnta_pkg::nnta_cmd_t dp_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AGE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [nnta_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic                        drain_reg, drain_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        accept;
    logic                        commit_ok;
    logic                        last_slot;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign commit_ok = !out_valid_reg || !out_stall;
    assign last_slot = (idx_reg == nnta_pkg::SLOT_W'(nnta_pkg::MAX_TRACKS - 1));
    assign out_valid = out_valid_reg;

    always_comb
    begin
        dp_cmd.load_frame = accept && (cmd == nnta_pkg::CMD_FRAME);
        dp_cmd.load_det   = accept && (cmd == nnta_pkg::CMD_DETECT);
        dp_cmd.age_en     = (state_reg == S_AGE);
        dp_cmd.scan_en    = (state_reg == S_SCAN);
        dp_cmd.commit     = (state_reg == S_COMMIT) && commit_ok;
        dp_cmd.idx        = idx_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    state_next = (cmd == nnta_pkg::CMD_FRAME) ? S_AGE : S_SCAN;
                end
            end
            S_AGE:
            begin
                idx_next = idx_reg + 1'b1;
                if (last_slot)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                idx_next   = idx_reg + 1'b1;
                drain_next = 1'b0;
                if (last_slot)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // let the distance pipeline empty before the commit
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (commit_ok)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/nnta_dp.sv
// datapath for the track association block: slot table, distance pipeline, result register
// depends on nnta_pkg; driven by nnta_ctrl

module nnta_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nnta_pkg::nnta_cmd_t                  dp_cmd,
    input  logic signed [nnta_pkg::POS_W-1:0]    pos_x_mm,
    input  logic signed [nnta_pkg::POS_W-1:0]    pos_y_mm,
    input  logic        [nnta_pkg::RADIUS_W-1:0] match_radius_mm,
    input  logic        [nnta_pkg::AGE_W-1:0]    age_limit,
    output logic        [nnta_pkg::ID_W-1:0]     track_id,
    output logic        [nnta_pkg::FRAMES_W-1:0] frames_seen,
    output logic                                 opened_new,
    output logic                                 table_full
);

    localparam int N = nnta_pkg::MAX_TRACKS;

    // slot table
    logic [N-1:0]                    slot_valid_reg;
    logic [N-1:0]                    slot_claimed_reg;
    logic [nnta_pkg::POS_W-1:0]      slot_x_reg      [N];
    logic [nnta_pkg::POS_W-1:0]      slot_y_reg      [N];
    logic [nnta_pkg::AGE_W-1:0]      slot_age_reg    [N];
    logic [nnta_pkg::FRAMES_W-1:0]   slot_frames_reg [N];
    logic [nnta_pkg::ID_W-1:0]       slot_ident_reg  [N];
    logic [nnta_pkg::ID_W-1:0]       next_ident_reg;

    // current detection and search results
    logic [nnta_pkg::POS_W-1:0]      det_x_reg;
    logic [nnta_pkg::POS_W-1:0]      det_y_reg;
    logic [nnta_pkg::DIST_W-1:0]     best_reg;
    logic [nnta_pkg::SLOT_W-1:0]     best_slot_reg;
    logic                            found_reg;
    logic [nnta_pkg::SLOT_W-1:0]     free_slot_reg;
    logic                            free_found_reg;

    // distance pipeline
    logic                            a_live_reg;
    logic [nnta_pkg::SLOT_W-1:0]     a_idx_reg;
    logic [nnta_pkg::POS_W-1:0]      a_dx_reg;
    logic [nnta_pkg::POS_W-1:0]      a_dy_reg;
    logic                            b_live_reg;
    logic [nnta_pkg::SLOT_W-1:0]     b_idx_reg;
    logic [nnta_pkg::SQ_W-1:0]       b_sqx_reg;
    logic [nnta_pkg::SQ_W-1:0]       b_sqy_reg;

    // result
    logic [nnta_pkg::ID_W-1:0]       track_id_reg;
    logic [nnta_pkg::FRAMES_W-1:0]   frames_seen_reg;
    logic                            opened_new_reg;
    logic                            table_full_reg;

    logic [2*nnta_pkg::RADIUS_W-1:0] radius_sq;
    logic [nnta_pkg::POS_W:0]        diff_x;
    logic [nnta_pkg::POS_W:0]        diff_y;
    logic [nnta_pkg::POS_W:0]        abs_x;
    logic [nnta_pkg::POS_W:0]        abs_y;
    logic [nnta_pkg::DIST_W-1:0]     dist_sq;
    logic                            scan_valid;
    logic                            scan_live;
    logic [nnta_pkg::AGE_W-1:0]      age_cur;
    logic [nnta_pkg::AGE_W-1:0]      age_inc;
    logic                            age_drop;
    logic                            hit;
    logic                            opening;
    logic [nnta_pkg::SLOT_W-1:0]     commit_slot;
    logic [nnta_pkg::FRAMES_W-1:0]   cur_frames;
    logic [nnta_pkg::FRAMES_W-1:0]   frames_inc;

    assign radius_sq  = match_radius_mm * match_radius_mm;

    assign scan_valid = slot_valid_reg[dp_cmd.idx];
    assign scan_live  = dp_cmd.scan_en && scan_valid && !slot_claimed_reg[dp_cmd.idx];

    // 17-bit differences, magnitude always fits 16 bits
    assign diff_x = {det_x_reg[nnta_pkg::POS_W-1], det_x_reg}
                  - {slot_x_reg[dp_cmd.idx][nnta_pkg::POS_W-1], slot_x_reg[dp_cmd.idx]};
    assign diff_y = {det_y_reg[nnta_pkg::POS_W-1], det_y_reg}
                  - {slot_y_reg[dp_cmd.idx][nnta_pkg::POS_W-1], slot_y_reg[dp_cmd.idx]};
    assign abs_x  = diff_x[nnta_pkg::POS_W] ? (~diff_x + 1'b1) : diff_x;
    assign abs_y  = diff_y[nnta_pkg::POS_W] ? (~diff_y + 1'b1) : diff_y;

    assign dist_sq = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};

    // aging of the slot under the sweep index
    assign age_cur  = slot_age_reg[dp_cmd.idx];
    assign age_inc  = (age_cur == '1) ? age_cur : age_cur + 1'b1;
    assign age_drop = age_inc > age_limit;

    assign hit         = found_reg;
    assign opening     = !found_reg && free_found_reg;
    assign commit_slot = found_reg ? best_slot_reg : free_slot_reg;
    assign cur_frames  = slot_frames_reg[commit_slot];
    assign frames_inc  = (cur_frames == '1) ? cur_frames : cur_frames + 1'b1;

    // control state: valid and claimed marks, search flags, pipeline valids, id counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg   <= '0;
            slot_claimed_reg <= '0;
            next_ident_reg   <= '0;
            found_reg        <= 1'b0;
            free_found_reg   <= 1'b0;
            a_live_reg       <= 1'b0;
            b_live_reg       <= 1'b0;
        end
        else
        begin
            a_live_reg <= scan_live;
            b_live_reg <= a_live_reg;
            if (dp_cmd.load_frame)
            begin
                slot_claimed_reg <= '0;
            end
            if (dp_cmd.load_det)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            if (dp_cmd.scan_en && !scan_valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (b_live_reg && (dist_sq < best_reg))
            begin
                found_reg <= 1'b1;
            end
            if (dp_cmd.age_en && scan_valid && age_drop)
            begin
                slot_valid_reg[dp_cmd.idx] <= 1'b0;
            end
            if (dp_cmd.commit && (hit || opening))
            begin
                slot_claimed_reg[commit_slot] <= 1'b1;
            end
            if (dp_cmd.commit && opening)
            begin
                slot_valid_reg[commit_slot] <= 1'b1;
                next_ident_reg              <= next_ident_reg + 1'b1;
            end
        end
    end

    // payload: detection, search values, pipeline data, slot contents, result
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_det)
        begin
            det_x_reg <= pos_x_mm;
            det_y_reg <= pos_y_mm;
            best_reg  <= nnta_pkg::DIST_W'(radius_sq);
        end
        if (dp_cmd.scan_en && !scan_valid && !free_found_reg)
        begin
            free_slot_reg <= dp_cmd.idx;
        end

        a_idx_reg <= dp_cmd.idx;
        a_dx_reg  <= abs_x[nnta_pkg::POS_W-1:0];
        a_dy_reg  <= abs_y[nnta_pkg::POS_W-1:0];
        b_idx_reg <= a_idx_reg;
        b_sqx_reg <= a_dx_reg * a_dx_reg;
        b_sqy_reg <= a_dy_reg * a_dy_reg;

        // strict compare keeps the lowest slot on ties
        if (b_live_reg && (dist_sq < best_reg))
        begin
            best_reg      <= dist_sq;
            best_slot_reg <= b_idx_reg;
        end

        if (dp_cmd.age_en && scan_valid)
        begin
            slot_age_reg[dp_cmd.idx] <= age_inc;
        end

        if (dp_cmd.commit)
        begin
            if (hit || opening)
            begin
                slot_x_reg[commit_slot]   <= det_x_reg;
                slot_y_reg[commit_slot]   <= det_y_reg;
                slot_age_reg[commit_slot] <= '0;
            end
            if (hit)
            begin
                slot_frames_reg[commit_slot] <= frames_inc;
                track_id_reg                 <= slot_ident_reg[commit_slot];
                frames_seen_reg              <= frames_inc;
            end
            else if (opening)
            begin
                slot_frames_reg[commit_slot] <= nnta_pkg::FRAMES_W'(1);
                slot_ident_reg[commit_slot]  <= next_ident_reg;
                track_id_reg                 <= next_ident_reg;
                frames_seen_reg              <= nnta_pkg::FRAMES_W'(1);
            end
            else
            begin
                track_id_reg    <= '0;
                frames_seen_reg <= '0;
            end
            opened_new_reg <= opening;
            table_full_reg <= !hit && !free_found_reg;
        end
    end

    assign track_id    = track_id_reg;
    assign frames_seen = frames_seen_reg;
    assign opened_new  = opened_new_reg;
    assign table_full  = table_full_reg;

endmodule

// File: hw/rtl/nearest_neighbor_track_association.sv
// top level of the greedy nearest-neighbor track association block
// depends on nnta_pkg, nnta_ctrl and nnta_dp

// Keeps a table of MAX_TRACKS (16) tracks and associates detections with them one item at a
// time. A frame-start item (cmd 0) is accepted and then runs an aging sweep over the slots,
// and gives no result. A detection item (cmd 1) is accepted, runs the distance scan over the
// slots, waits while the three-stage distance pipeline (difference, square, compare) drains,
// and is then committed, which registers the result and raises out_valid.
// The slot scan runs one slot per cycle through a single subtract/square/compare pipeline.
// A new item is taken as soon as the block is back in idle, even while the last result still
// waits on out_stall; the commit of the next detection then waits until the result register
// is free. Configuration goes through the APB port: match_radius_mm at byte address 0 (reset
// 500) and age_limit at byte address 4 (reset 10); write only while idle.

module nearest_neighbor_track_association
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    // apb configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic        [nnta_pkg::APB_ADDR_W-1:0] paddr,
    input  logic        [nnta_pkg::APB_DATA_W-1:0] pwdata,
    output logic        [nnta_pkg::APB_DATA_W-1:0] prdata,
    output logic                                   pready,

    // input item channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   cmd,
    input  logic signed [nnta_pkg::POS_W-1:0]      pos_x_mm,
    input  logic signed [nnta_pkg::POS_W-1:0]      pos_y_mm,

    // result item channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic        [nnta_pkg::ID_W-1:0]       track_id,
    output logic        [nnta_pkg::FRAMES_W-1:0]   frames_seen,
    output logic                                   opened_new,
    output logic                                   table_full
);

    logic [nnta_pkg::RADIUS_W-1:0] radius_reg;
    logic [nnta_pkg::AGE_W-1:0]    age_limit_reg;
    logic                          cfg_write;
    nnta_pkg::reg_index_t          reg_sel;
    nnta_pkg::nnta_cmd_t           dp_cmd;

    // apb: zero wait states, registers sit on 4-byte boundaries
    assign pready    = 1'b1;
    assign reg_sel   = nnta_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= nnta_pkg::RADIUS_RESET;
            age_limit_reg <= nnta_pkg::AGE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                nnta_pkg::REG_MATCH_RADIUS: radius_reg    <= pwdata[nnta_pkg::RADIUS_W-1:0];
                nnta_pkg::REG_AGE_LIMIT:    age_limit_reg <= pwdata[nnta_pkg::AGE_W-1:0];
                default:                    radius_reg    <= radius_reg;
            endcase
        end
    end

    // read back, upper bits zero
    always_comb
    begin
        case (reg_sel)
            nnta_pkg::REG_MATCH_RADIUS: prdata = nnta_pkg::APB_DATA_W'(radius_reg);
            nnta_pkg::REG_AGE_LIMIT:    prdata = nnta_pkg::APB_DATA_W'(age_limit_reg);
            default:                    prdata = '0;
        endcase
    end

    // sequencer: aging sweep, scan, drain, commit
    nnta_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd)
    );

    // slot table, distance pipeline and result register
    nnta_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_cmd          (dp_cmd),
        .pos_x_mm        (pos_x_mm),
        .pos_y_mm        (pos_y_mm),
        .match_radius_mm (radius_reg),
        .age_limit       (age_limit_reg),
        .track_id        (track_id),
        .frames_seen     (frames_seen),
        .opened_new      (opened_new),
        .table_full      (table_full)
    );

endmodule

// File: tb/track_assoc_checker.sv
// checker for the track association block: mirrors the track table and predicts
// the report of every detection, then compares it with the result channel
// depends on nnta_pkg

module track_assoc_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic                                   pready,
    input  logic        [nnta_pkg::APB_ADDR_W-1:0] paddr,
    input  logic        [nnta_pkg::APB_DATA_W-1:0] pwdata,

    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic                                   cmd,
    input  logic signed [nnta_pkg::POS_W-1:0]      pos_x_mm,
    input  logic signed [nnta_pkg::POS_W-1:0]      pos_y_mm,

    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic        [nnta_pkg::ID_W-1:0]       track_id,
    input  logic        [nnta_pkg::FRAMES_W-1:0]   frames_seen,
    input  logic                                   opened_new,
    input  logic                                   table_full,

    output int                                     fail_count,
    output int                                     pending,
    output int                                     n_matched,
    output int                                     n_opened,
    output int                                     n_full
);
    import nnta_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]     ident;
        logic [FRAMES_W-1:0] frames;
        logic                opened;
        logic                full;
    } track_report_t;

    // mirrored track table
    logic                    trk_live    [MAX_TRACKS];
    logic                    trk_claimed [MAX_TRACKS];
    logic signed [POS_W-1:0] trk_x       [MAX_TRACKS];
    logic signed [POS_W-1:0] trk_y       [MAX_TRACKS];
    logic [AGE_W-1:0]        trk_age     [MAX_TRACKS];
    logic [FRAMES_W-1:0]     trk_frames  [MAX_TRACKS];
    logic [ID_W-1:0]         trk_ident   [MAX_TRACKS];
    logic [ID_W-1:0]         ident_next;

    logic [RADIUS_W-1:0]     radius;
    logic [AGE_W-1:0]        age_max;

    track_report_t           reports_due [$];
    track_report_t           want;
    track_report_t           predicted;
    reg_index_t              reg_sel;
    int                      errs        = 0;
    int                      matched_cnt = 0;
    int                      opened_cnt  = 0;
    int                      full_cnt    = 0;

    // frame start: age live tracks, drop stale ones, release claims
    function automatic void age_tracks();
        for (int i = 0; i < MAX_TRACKS; i++)
        begin
            trk_claimed[i] = 1'b0;
            if (trk_live[i])
            begin
                if (trk_age[i] != {AGE_W{1'b1}})
                    trk_age[i] = trk_age[i] + 1'b1;
                if (trk_age[i] > age_max)
                    trk_live[i] = 1'b0;
            end
        end
    endfunction

    // nearest unclaimed track strictly in radius, else open one, else full
    function automatic track_report_t associate(input logic signed [POS_W-1:0] x,
                                                input logic signed [POS_W-1:0] y);
        longint        best;
        longint        dx;
        longint        dy;
        longint        d_sq;
        int            hit;
        int            free_slot;
        track_report_t rep;
        best      = longint'(radius) * longint'(radius);
        hit       = -1;
        free_slot = -1;
        rep       = '0;
        for (int i = 0; i < MAX_TRACKS; i++)
        begin
            if (!trk_live[i])
            begin
                if (free_slot < 0)
                    free_slot = i;
            end
            else if (!trk_claimed[i])
            begin
                dx   = longint'(x) - longint'(trk_x[i]);
                dy   = longint'(y) - longint'(trk_y[i]);
                d_sq = dx * dx + dy * dy;
                // strict compare keeps the lowest slot on ties
                if (d_sq < best)
                begin
                    best = d_sq;
                    hit  = i;
                end
            end
        end
        if (hit >= 0)
        begin
            trk_x[hit]       = x;
            trk_y[hit]       = y;
            trk_age[hit]     = '0;
            if (trk_frames[hit] != {FRAMES_W{1'b1}})
                trk_frames[hit] = trk_frames[hit] + 1'b1;
            trk_claimed[hit] = 1'b1;
            rep.ident        = trk_ident[hit];
            rep.frames       = trk_frames[hit];
            matched_cnt++;
        end
        else if (free_slot >= 0)
        begin
            trk_live[free_slot]    = 1'b1;
            trk_x[free_slot]       = x;
            trk_y[free_slot]       = y;
            trk_age[free_slot]     = '0;
            trk_frames[free_slot]  = FRAMES_W'(1);
            trk_ident[free_slot]   = ident_next;
            trk_claimed[free_slot] = 1'b1;
            ident_next             = ident_next + 1'b1;
            rep.ident              = trk_ident[free_slot];
            rep.frames             = FRAMES_W'(1);
            rep.opened             = 1'b1;
            opened_cnt++;
        end
        else
        begin
            rep.full = 1'b1;
            full_cnt++;
        end
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TRACKS; i++)
            begin
                trk_live[i]    = 1'b0;
                trk_claimed[i] = 1'b0;
                trk_x[i]       = '0;
                trk_y[i]       = '0;
                trk_age[i]     = '0;
                trk_frames[i]  = '0;
                trk_ident[i]   = '0;
            end
            ident_next = '0;
            radius     = RADIUS_RESET;
            age_max    = AGE_LIMIT_RESET;
            reports_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                reg_sel = reg_index_t'(paddr[APB_ADDR_W-1:2]);
                if (reg_sel == REG_MATCH_RADIUS)
                    radius = pwdata[RADIUS_W-1:0];
                else if (reg_sel == REG_AGE_LIMIT)
                    age_max = pwdata[AGE_W-1:0];
            end

            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("unexpected track report: track_id %0d frames_seen %0d",
                           track_id, frames_seen);
                    errs++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("track_id", want.ident, track_id);
                    check_field("frames_seen", want.frames, frames_seen);
                    check_field("opened_new", 16'(want.opened), 16'(opened_new));
                    check_field("table_full", 16'(want.full), 16'(table_full));
                end
            end

            if (in_valid && !in_stall)
            begin
                if (cmd == CMD_FRAME)
                    age_tracks();
                else
                begin
                    predicted   = associate(pos_x_mm, pos_y_mm);
                    reports_due = {reports_due, predicted};
                end
            end
        end
        fail_count <= errs;
        pending    <= reports_due.size();
        n_matched  <= matched_cnt;
        n_opened   <= opened_cnt;
        n_full     <= full_cnt;
    end

endmodule

// File: tb/testbench.sv
// top of the track association testbench: clock, reset, stimulus and verdict
// depends on nnta_pkg, nearest_neighbor_track_association and track_assoc_checker

module testbench;
    import nnta_pkg::*;

    logic                    clk;
    logic                    rst_n;

    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    logic                    in_valid;
    logic                    in_stall;
    logic                    cmd;
    logic signed [POS_W-1:0] pos_x_mm;
    logic signed [POS_W-1:0] pos_y_mm;

    logic                    out_valid;
    logic                    out_stall;
    logic [ID_W-1:0]         track_id;
    logic [FRAMES_W-1:0]     frames_seen;
    logic                    opened_new;
    logic                    table_full;

    int                      fail_count;
    int                      pending;
    int                      n_matched;
    int                      n_opened;
    int                      n_full;

    // idle shaping, shared with the receiver and hold-off processes
    int                      send_idle_pct;
    int                      recv_stall_pct;
    logic                    hold_off;
    logic                    pressure_req;

    // item counts and the radius currently programmed
    int                      det_sent;
    int                      frame_sent;
    int                      cur_radius;

    // scene of moving objects that feeds well-formed detections
    localparam int N_OBJ = 12;
    int                      obj_x    [N_OBJ];
    int                      obj_y    [N_OBJ];
    bit                      obj_live [N_OBJ];

    nearest_neighbor_track_association i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .pos_x_mm    (pos_x_mm),
        .pos_y_mm    (pos_y_mm),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .track_id    (track_id),
        .frames_seen (frames_seen),
        .opened_new  (opened_new),
        .table_full  (table_full)
    );

    track_assoc_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .pos_x_mm    (pos_x_mm),
        .pos_y_mm    (pos_y_mm),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .track_id    (track_id),
        .frames_seen (frames_seen),
        .opened_new  (opened_new),
        .table_full  (table_full),
        .fail_count  (fail_count),
        .pending     (pending),
        .n_matched   (n_matched),
        .n_opened    (n_opened),
        .n_full      (n_full)
    );

    // 12 unit clock period
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(64'd18_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stall each cycle, forced high during a hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // one long receiver hold-off so the result register and the input both back up
    initial
    begin
        hold_off = 1'b0;
        wait (pressure_req);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    function automatic bit chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int clamp16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // full-range position with the extremes weighted up
    function automatic int noise_pos();
        case ($urandom_range(7))
            0:       return -32768;
            1:       return 32767;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // object motion per frame, scaled to the match radius
    function automatic int wobble();
        int j;
        j = cur_radius / 3;
        return int'($urandom_range(2 * j)) - j;
    endfunction

    // one item on the input channel; called at any time after a posedge or
    // negedge, returns right after the accepting edge with valid still high
    task automatic send_item(input logic c, input logic [15:0] x, input logic [15:0] y);
        @(negedge clk);
        while (chance(send_idle_pct))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        pos_x_mm <= x;
        pos_y_mm <= y;
        do
            @(posedge clk);
        while (in_stall);
        if (c == CMD_DETECT)
            det_sent++;
        else
            frame_sent++;
    endtask

    task automatic send_frame();
        send_item(CMD_FRAME, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_detect(input int x, input int y);
        send_item(CMD_DETECT, x[15:0], y[15:0]);
    endtask

    // drop valid, wait for every report, then cover a trailing frame start sweep
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MATCH_RADIUS)
            cur_radius = int'(value & 32'h7FFF);
    endtask

    // register settings and idle mix per phase; upper bits are set on purpose
    // in some writes to check that only the register width is kept
    task automatic configure_phase(input int p);
        case (p)
            0:
            begin
                write_reg(REG_MATCH_RADIUS, 32'd1200);
                write_reg(REG_AGE_LIMIT, 32'd3);
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                // zero radius: nothing can join, the table fills quickly
                write_reg(REG_MATCH_RADIUS, 32'd0);
                write_reg(REG_AGE_LIMIT, 32'd0);
                send_idle_pct  = 59;
                recv_stall_pct = 0;
            end
            2:
            begin
                write_reg(REG_MATCH_RADIUS, 32'd32767);
                write_reg(REG_AGE_LIMIT, 32'd254);
                send_idle_pct  = 0;
                recv_stall_pct = 59;
            end
            3:
            begin
                // radius 300 and age limit 255 once masked
                write_reg(REG_MATCH_RADIUS, 32'hFFFF_812C);
                write_reg(REG_AGE_LIMIT, 32'hFFFF_FFFF);
                send_idle_pct  = 35;
                recv_stall_pct = 35;
            end
            default:
            begin
                // radius 500 once masked; saturated ages left over get dropped
                write_reg(REG_MATCH_RADIUS, 32'h0001_01F4);
                write_reg(REG_AGE_LIMIT, 32'd1);
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // one random frame: mostly a scene update, sometimes noise or broken shapes
    task automatic play_frame();
        int r;
        int k;
        int n;
        send_frame();
        r = $urandom_range(99);
        if (r < 75)
        begin
            for (k = 0; k < N_OBJ; k++)
            begin
                if (obj_live[k] && chance(85))
                begin
                    obj_x[k] = clamp16(obj_x[k] + wobble());
                    obj_y[k] = clamp16(obj_y[k] + wobble());
                    send_detect(obj_x[k], obj_y[k]);
                    // a second hit on the same object finds its track claimed
                    if (chance(8))
                        send_detect(clamp16(obj_x[k] + wobble()), obj_y[k]);
                end
            end
            if (chance(25))
            begin
                k = $urandom_range(N_OBJ - 1);
                obj_live[k] = 1'b1;
                obj_x[k]    = noise_pos();
                obj_y[k]    = noise_pos();
            end
            if (chance(15))
                obj_live[$urandom_range(N_OBJ - 1)] = 1'b0;
        end
        else if (r < 90)
        begin
            n = $urandom_range(6, 1);
            repeat (n) send_detect(noise_pos(), noise_pos());
        end
        else if (r < 95)
        begin
            // long run with no frame start fills the table
            n = $urandom_range(24, 12);
            repeat (n) send_detect(noise_pos(), noise_pos());
        end
        else
        begin
            n = $urandom_range(4, 1);
            repeat (n) send_frame();
        end
    endtask

    initial
    begin
        int phase_end;
        int k;
        bit burst_done;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        cmd            = CMD_FRAME;
        pos_x_mm       = '0;
        pos_y_mm       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_req   = 1'b0;
        det_sent       = 0;
        frame_sent     = 0;
        cur_radius     = 500;
        for (k = 0; k < N_OBJ; k++)
        begin
            obj_live[k] = (k < 6);
            obj_x[k]    = int'($urandom_range(40000)) - 20000;
            obj_y[k]    = int'($urandom_range(40000)) - 20000;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part with reset settings (radius 500, age limit 10)
        send_detect(0, 0);              // opens the first track
        send_detect(0, 0);              // first track claimed, opens a second
        send_frame();
        send_detect(0, 0);              // equal distance to both, lowest slot wins
        send_detect(499, 0);            // just inside the radius, joins the second
        send_detect(0, 500);            // both claimed, opens a third
        send_frame();
        send_detect(0, 1000);           // exactly on the radius, no join
        send_detect(32767, 32767);      // corner positions
        send_detect(-32768, -32768);
        send_detect(-32768, 32767);
        send_detect(32767, -32768);
        for (k = 0; k < 8; k++)
            send_detect(-20000 + 4000 * k, 5000);
        send_detect(10000, -10000);     // no free slot left
        send_frame();
        drain();

        // random phases, each with its own register settings and idle mix
        for (int p = 0; p < 5; p++)
        begin
            configure_phase(p);
            phase_end  = det_sent + frame_sent + 320;
            burst_done = 1'b0;
            while (det_sent + frame_sent < phase_end)
            begin
                // long quiet stretch lets track ages saturate
                if (p == 3 && !burst_done && det_sent + frame_sent > phase_end - 160)
                begin
                    repeat (260) send_frame();
                    burst_done = 1'b1;
                end
                // receiver hold-off with the sender still offering items
                if (p == 4 && !pressure_req && det_sent + frame_sent > phase_end - 220)
                    pressure_req = 1'b1;
                play_frame();
            end
            drain();
        end

        $display("run covered %0d detections and %0d frame starts over five setting phases",
                 det_sent, frame_sent);
        $display("reports: %0d joined a track, %0d opened one, %0d found the table full",
                 n_matched, n_opened, n_full);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/nnta_pkg.sv
hw/rtl/nnta_ctrl.sv
hw/rtl/nnta_dp.sv
hw/rtl/nearest_neighbor_track_association.sv
tb/track_assoc_checker.sv
tb/testbench.sv
